>>> design/ssp_pkg.sv
package ssp_pkg;

   // Field widths
   localparam int SIZE_BITS  = 12;
   localparam int POS_BITS   = 17;
   localparam int WORD_BITS  = 32;
   localparam int PHASE_RES  = 6;

   // Dividend is source_size << 16, so the quotient has 28 bits
   localparam int NUM_BITS       = SIZE_BITS + 16;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = NUM_BITS / BITS_PER_STAGE;
   localparam int LATENCY        = DIV_STAGES + 1;

   // Step field is placed at bit 8, so 24 of its bits survive in the word
   localparam int STEP_KEEP = WORD_BITS - 8;
   localparam logic [STEP_KEEP-1:0] STEP_FLAG_ADD = STEP_KEEP'(1) << (30 - 8);

   // Start phase offsets: half a pixel for luma, a quarter for chroma
   localparam logic [PHASE_RES:0] LUMA_OFFSET   = (PHASE_RES+1)'((1 << PHASE_RES) >> 1);
   localparam logic [PHASE_RES:0] CHROMA_OFFSET = (PHASE_RES+1)'((1 << PHASE_RES) >> 2);
   localparam logic signed [PHASE_RES+1:0] PHASE_MAX =
      (PHASE_RES+2)'((1 << PHASE_RES) - 1);

   typedef struct packed {
      logic [SIZE_BITS-1:0] source_size;
      logic [SIZE_BITS-1:0] scaled_size;
      logic [POS_BITS-1:0]  position;
      logic                 chroma_select;
   } ssp_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] filter_word;
      logic                 divide_by_zero;
   } ssp_rsp_type;

   // One divider pipeline slot: partial remainder, combined numerator/quotient
   // shift register, and the side data carried alongside
   typedef struct packed {
      logic [SIZE_BITS-1:0]         rem;
      logic [NUM_BITS-1:0]          nq;
      logic [SIZE_BITS-1:0]         divisor;
      logic                         chroma_select;
      logic signed [PHASE_RES:0]    base;
   } ssp_div_type;

endpackage

>>> design/ssp_div_stage.sv
module ssp_div_stage
   import ssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   input  ssp_div_type up_data,
   output logic        dn_valid,
   output ssp_div_type dn_data
);

   logic        dn_valid_ff;
   ssp_div_type dn_data_ff;
   ssp_div_type dn_data_in;

   // Two restoring steps per stage; nq shifts numerator out the top,
   // quotient bits in at the bottom
   always_comb begin
      logic [SIZE_BITS:0]   part;
      logic [SIZE_BITS-1:0] rem;
      logic [NUM_BITS-1:0]  nq;
      logic                 ge;
      rem = up_data.rem;
      nq  = up_data.nq;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         part = {rem, nq[NUM_BITS-1]};
         ge   = part >= {1'b0, up_data.divisor};
         if (ge) begin
            rem = SIZE_BITS'(part - {1'b0, up_data.divisor});
         end else begin
            rem = part[SIZE_BITS-1:0];
         end
         nq = {nq[NUM_BITS-2:0], ge};
      end
      dn_data_in     = up_data;
      dn_data_in.rem = rem;
      dn_data_in.nq  = nq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else begin
         dn_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      dn_data_ff <= dn_data_in;
   end

   assign dn_valid = dn_valid_ff;
   assign dn_data  = dn_data_ff;

endmodule

>>> design/ssp_word.sv
module ssp_word
   import ssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        div_valid,
   input  ssp_div_type div_data,
   output logic        rsp_valid,
   output ssp_rsp_type rsp_item
);

   logic        rsp_valid_ff;
   ssp_rsp_type rsp_item_ff;
   ssp_rsp_type rsp_item_in;

   always_comb begin
      logic [NUM_BITS-1:0]             step;
      logic signed [PHASE_RES+1:0]     phase;
      logic [PHASE_RES:0]              phase7;
      step = div_data.nq;
      if (!div_data.chroma_select) begin
         step[0] = 1'b0;
      end
      // rem >> 11: only the top remainder bit reaches the phase
      phase = {div_data.base[PHASE_RES], div_data.base}
            + (PHASE_RES+2)'(div_data.rem[SIZE_BITS-1]);
      if (phase > PHASE_MAX) begin
         phase = PHASE_MAX;
      end
      phase7 = phase[PHASE_RES:0];
      // Phase fits below bit 8, so only the flag bit needs an add
      if (div_data.divisor == '0) begin
         rsp_item_in.filter_word    = '0;
         rsp_item_in.divide_by_zero = 1'b1;
      end else begin
         rsp_item_in.filter_word    = {step[STEP_KEEP-1:0] + STEP_FLAG_ADD, 1'b0, phase7};
         rsp_item_in.divide_by_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> design/scaler_step_phase_word.sv
// Polyphase scaler control word generator. Each item gives a source size,
// a scaled size, a position and a luma/chroma select, and returns one
// 32-bit control word: the 12.16 step (source << 16) / scaled from bit 8
// up (bit 0 cleared for luma, top bits dropped) with 1 << 30 added, and a
// 7-bit two's complement start phase in the low bits. A scaled size of
// zero returns word 0 with divide_by_zero set. An item may be started in
// every cycle; busy never rises. Each result appears on rsp_item for
// exactly one cycle, flagged by rsp_valid, after the divider pipeline (two
// quotient bits per stage) and a registered word assembly stage. The
// receiver cannot stall, so results must be taken as they come.
module scaler_step_phase_word
   import ssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ssp_req_type req_item,
   output logic        rsp_valid,
   output ssp_rsp_type rsp_item
);

   logic        stage_valid [0:DIV_STAGES];
   ssp_div_type stage_data  [0:DIV_STAGES];

   // Nothing ever holds the pipe, so the block is always free
   assign busy = 1'b0;

   // Entry: load dividend, work out the position part of the start phase
   always_comb begin
      stage_valid[0]              = start && !busy;
      stage_data[0].rem           = '0;
      stage_data[0].nq            = {req_item.source_size, 16'd0};
      stage_data[0].divisor       = req_item.scaled_size;
      stage_data[0].chroma_select = req_item.chroma_select;
      if (req_item.chroma_select) begin
         // quarter-pixel offset, position in half-resolution units
         stage_data[0].base = {1'b0, req_item.position[16:11]} - CHROMA_OFFSET;
      end else begin
         // half-pixel offset
         stage_data[0].base = {1'b0, req_item.position[15:10]} - LUMA_OFFSET;
      end
   end

   // Divider pipeline
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      ssp_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[s]),
         .up_data  (stage_data[s]),
         .dn_valid (stage_valid[s+1]),
         .dn_data  (stage_data[s+1])
      );
   end

   // Step fix-up, phase clamp and word packing
   ssp_word u_word (
      .clock     (clock),
      .reset     (reset),
      .div_valid (stage_valid[DIV_STAGES]),
      .div_data  (stage_data[DIV_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Every started item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item lost in pipeline");

   // Zero divisor flag lines up with the item that caused it
   a_dbz_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.divide_by_zero ==
                     $past(req_item.scaled_size == '0, LATENCY)))
      else $error("divide_by_zero out of step with item");

   a_dbz_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.divide_by_zero) |-> (rsp_item.filter_word == '0))
      else $error("word not forced to zero on zero divisor");

   // Luma step must be even
   a_luma_even: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.divide_by_zero && !$past(req_item.chroma_select, LATENCY))
      |-> (rsp_item.filter_word[8] == 1'b0))
      else $error("luma step bit 0 not cleared");

endmodule
